// File: sv/cmsd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and handshake structs for the column mean / std-dev core.
package cmsd_pkg;

   localparam int MAX_ROWS    = 65536;
   localparam int MAX_COLUMNS = 4096;

   // field and accumulator widths
   localparam int SAMPLE_W = 24;
   localparam int SUM_W    = 40;
   localparam int SQ_W     = 63;
   localparam int CNT_W    = 17;
   localparam int COL_W    = 12;
   localparam int MEAN_W   = 24;
   localparam int STD_W    = 25;
   localparam int PROD_W   = 2 * SAMPLE_W;

   // end-of-column datapath widths
   localparam int ALU_W    = 82;  // signed n*sumsq - sum^2 fits with margin
   localparam int NUM_W    = 80;  // dividend shift register
   localparam int MNUM_W   = SUM_W + 1;
   localparam int REM_W    = 33;
   localparam int DSOR_W   = 32;
   localparam int QUO_W    = 48;
   localparam int ROOT_W   = 25;
   localparam int STEP_W   = 7;

   localparam logic [CNT_W-1:0]  ROW_LIMIT = CNT_W'(MAX_ROWS);
   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAX_COLUMNS - 1);
   localparam logic [STD_W-1:0]  STD_ONE   = STD_W'(4096);

   // iteration counts, loaded as count-1
   localparam logic [STEP_W-1:0] MDIV_LAST = STEP_W'(MNUM_W - 1);
   localparam logic [STEP_W-1:0] MULA_LAST = STEP_W'(CNT_W - 1);
   localparam logic [STEP_W-1:0] MULB_LAST = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] QDIV_LAST = STEP_W'(NUM_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(QUO_W / 2 - 1);

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sumsq;
      logic [CNT_W-1:0]        n;
      logic                    ovf;
   } col_stats_type;

   typedef struct packed {
      logic take;
      logic accum;
      logic clear;
   } acc_ctrl_type;

   typedef struct packed {
      logic start;
      logic ack;
   } seq_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [STD_W-1:0]  std;
      logic              ovf;
   } col_result_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage

// File: sv/cmsd_alu.sv
`timescale 1ns / 1ps
// Shared wide add/subtract unit used by the end-of-column sequencer's arithmetic steps.
module cmsd_alu import cmsd_pkg::*; (
   input  alu_req_type      req,
   output logic [ALU_W-1:0] res,
   output logic             cout
);

   logic [ALU_W:0] full;

   // for subtract, cout high means a >= b (unsigned)
   always_comb begin
      full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{ALU_W{1'b0}}, req.sub};
      res  = full[ALU_W-1:0];
      cout = full[ALU_W];
   end

endmodule

// File: sv/cmsd_accum.sv
`timescale 1ns / 1ps
// Per-sample accumulation: running sum, sum of squares, row count, overflow flag.
module cmsd_accum import cmsd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  acc_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   output col_stats_type              stats
);

   logic signed [SAMPLE_W-1:0] x_ff;
   logic [PROD_W-1:0]          sq_ff;
   logic signed [PROD_W-1:0]   sq_full;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    ovf_ff, ovf_in;

   assign sq_full = sample * sample;

   always_comb begin
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      if (ctrl.clear) begin
         sum_in   = '0;
         sumsq_in = '0;
         cnt_in   = '0;
         ovf_in   = 1'b0;
      end else if (ctrl.accum) begin
         // past the row limit the beat only marks overflow
         if (cnt_ff >= ROW_LIMIT) begin
            ovf_in = 1'b1;
         end else begin
            sum_in   = sum_ff + SUM_W'(x_ff);
            sumsq_in = sumsq_ff + SQ_W'(sq_ff);
            cnt_in   = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         x_ff  <= sample;
         sq_ff <= sq_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign stats.sum   = sum_ff;
   assign stats.sumsq = sumsq_ff;
   assign stats.n     = cnt_ff;
   assign stats.ovf   = ovf_ff;

endmodule

// File: sv/cmsd_seq.sv
`timescale 1ns / 1ps
// End-of-column sequencer: mean divide, n*sumsq - sum^2, variance divide, root.
module cmsd_seq import cmsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  seq_ctrl_type   ctrl,
   input  col_stats_type  stats,
   output seq_stat_type   stat,
   output col_result_type result
);

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_LOADM, S_MDIV, S_MULA, S_MULB,
      S_CHECK, S_QDIV, S_LOADR, S_SQRT, S_FIN, S_DONE
   } seq_state_type;

   seq_state_type st_ff;
   logic [STEP_W-1:0] cnt_ff;

   logic signed [SUM_W-1:0] sum_ff;
   logic [SQ_W-1:0]   sumsq_ff;
   logic [CNT_W-1:0]  n_ff;
   logic              ovf_ff;
   logic [SUM_W-1:0]  mag_ff;
   logic [DSOR_W-1:0] prod_ff;
   logic [DSOR_W-1:0] dsor_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [ALU_W-1:0]  d_ff;
   logic [ALU_W-1:0]  mc_ff;
   logic [SUM_W-1:0]  mp_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic [STD_W-1:0]  std_ff;

   alu_req_type       alu_req;
   logic [ALU_W-1:0]  alu_res;
   logic              alu_cout;

   logic [REM_W-1:0]    trial_div;
   logic [REM_W-1:0]    trial_sqrt;
   logic [ROOT_W+1:0]   root_trial;
   logic [2*CNT_W-1:0]  nn_full;
   logic [MEAN_W-1:0]   quo_lo;
   logic [MEAN_W-1:0]   mean_code;
   logic                d_pos;

   cmsd_alu u_alu (
      .req  (alu_req),
      .res  (alu_res),
      .cout (alu_cout)
   );

   assign trial_div  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign trial_sqrt = {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]};
   assign root_trial = {root_ff, 2'b01};
   assign nn_full    = (2*CNT_W)'(n_ff) * (2*CNT_W)'(n_ff - CNT_W'(1));
   assign quo_lo     = quo_ff[MEAN_W-1:0];
   assign d_pos      = !d_ff[ALU_W-1] && (|d_ff);

   always_comb begin
      if (n_ff == '0) begin
         mean_code = '0;
      end else if (sum_ff[SUM_W-1]) begin
         mean_code = ~quo_lo + MEAN_W'(1);
      end else begin
         mean_code = quo_lo;
      end
   end

   always_comb begin
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      unique case (st_ff)
         S_PREP: begin  // 0 - sum
            alu_req.b   = ALU_W'(sum_ff);
            alu_req.sub = 1'b1;
         end
         S_LOADM: begin  // 2*|sum| + n, rounding numerator
            alu_req.a = ALU_W'({mag_ff, 1'b0});
            alu_req.b = ALU_W'(n_ff);
         end
         S_MDIV, S_QDIV: begin
            alu_req.a   = ALU_W'(trial_div);
            alu_req.b   = ALU_W'(dsor_ff);
            alu_req.sub = 1'b1;
         end
         S_MULA: begin
            alu_req.a = d_ff;
            alu_req.b = mc_ff;
         end
         S_MULB: begin
            alu_req.a   = d_ff;
            alu_req.b   = mc_ff;
            alu_req.sub = 1'b1;
         end
         S_SQRT: begin
            alu_req.a   = ALU_W'(trial_sqrt);
            alu_req.b   = ALU_W'(root_trial);
            alu_req.sub = 1'b1;
         end
         default: begin
            alu_req.sub = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (ctrl.start) begin
                  sum_ff   <= stats.sum;
                  sumsq_ff <= stats.sumsq;
                  n_ff     <= stats.n;
                  ovf_ff   <= stats.ovf;
                  st_ff    <= S_PREP;
               end
            end
            S_PREP: begin
               mag_ff  <= sum_ff[SUM_W-1] ? alu_res[SUM_W-1:0] : sum_ff;
               prod_ff <= nn_full[DSOR_W-1:0];
               st_ff   <= S_LOADM;
            end
            S_LOADM: begin
               num_ff  <= {alu_res[MNUM_W-1:0], {(NUM_W-MNUM_W){1'b0}}};
               dsor_ff <= DSOR_W'({n_ff, 1'b0});
               rem_ff  <= '0;
               quo_ff  <= '0;
               cnt_ff  <= MDIV_LAST;
               st_ff   <= S_MDIV;
            end
            S_MDIV, S_QDIV: begin
               rem_ff <= alu_cout ? alu_res[REM_W-1:0] : trial_div;
               quo_ff <= {quo_ff[QUO_W-2:0], alu_cout};
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               if (cnt_ff == '0) begin
                  if (st_ff == S_MDIV) begin
                     d_ff   <= '0;
                     mc_ff  <= ALU_W'(sumsq_ff);
                     mp_ff  <= SUM_W'(n_ff);
                     cnt_ff <= MULA_LAST;
                     st_ff  <= S_MULA;
                  end else begin
                     st_ff <= S_LOADR;
                  end
               end else begin
                  cnt_ff <= cnt_ff - STEP_W'(1);
               end
            end
            S_MULA, S_MULB: begin
               // shift-add: n*sumsq first, then subtract |sum|*|sum|
               if (mp_ff[0]) begin
                  d_ff <= alu_res;
               end
               if (cnt_ff == '0) begin
                  if (st_ff == S_MULA) begin
                     mc_ff  <= ALU_W'(mag_ff);
                     mp_ff  <= mag_ff;
                     cnt_ff <= MULB_LAST;
                     st_ff  <= S_MULB;
                  end else begin
                     st_ff <= S_CHECK;
                  end
               end else begin
                  cnt_ff <= cnt_ff - STEP_W'(1);
                  mc_ff  <= {mc_ff[ALU_W-2:0], 1'b0};
                  mp_ff  <= {1'b0, mp_ff[SUM_W-1:1]};
               end
            end
            S_CHECK: begin
               mean_ff <= mean_code;
               if ((n_ff > CNT_W'(1)) && d_pos) begin
                  num_ff  <= d_ff[NUM_W-1:0];
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  dsor_ff <= prod_ff;
                  cnt_ff  <= QDIV_LAST;
                  st_ff   <= S_QDIV;
               end else begin
                  std_ff <= STD_ONE;
                  st_ff  <= S_DONE;
               end
            end
            S_LOADR: begin
               num_ff  <= {quo_ff, {(NUM_W-QUO_W){1'b0}}};
               rem_ff  <= '0;
               root_ff <= '0;
               cnt_ff  <= SQRT_LAST;
               st_ff   <= S_SQRT;
            end
            S_SQRT: begin
               // two radicand bits per step
               rem_ff  <= alu_cout ? alu_res[REM_W-1:0] : trial_sqrt;
               root_ff <= {root_ff[ROOT_W-2:0], alu_cout};
               num_ff  <= {num_ff[NUM_W-3:0], 2'b00};
               cnt_ff  <= cnt_ff - STEP_W'(1);
               if (cnt_ff == '0) begin
                  st_ff <= S_FIN;
               end
            end
            S_FIN: begin
               std_ff <= root_ff;
               st_ff  <= S_DONE;
            end
            S_DONE: begin
               if (ctrl.ack) begin
                  st_ff <= S_IDLE;
               end
            end
            default: begin
               st_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign stat.busy     = (st_ff != S_IDLE);
   assign stat.done     = (st_ff == S_DONE);
   assign result.mean   = mean_ff;
   assign result.std    = std_ff;
   assign result.ovf    = ovf_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (st_ff == S_IDLE))
      else $error("start while sequencer busy");

   a_qdiv_rem: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_QDIV) |-> (!rem_ff[REM_W-1] && (rem_ff[DSOR_W-1:0] < dsor_ff)))
      else $error("variance divide remainder out of range");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_SQRT) |-> (rem_ff[REM_W-1:ROOT_W+1] == '0))
      else $error("root remainder out of range");

endmodule

// File: sv/column_mean_and_std_dev_core.sv
`timescale 1ns / 1ps
// Top level: sample handshake, accumulator, end-of-column sequencer, result register.
//
//   channel  dir  ports                                         beat taken when
//   req      in   req_sample_value, req_last_in_column          req_valid && !req_stall
//   rsp      out  rsp_column_index, rsp_column_mean,            rsp_valid && !rsp_stall
//                 rsp_column_std_dev, rsp_row_overflow
//
// A sample beat is captured and squared, then accumulated.
// A last beat then runs the end-of-column steps in the shared add/sub unit: 41 mean-divide
// steps, 17 + 40 shift-add steps, 80 variance-divide steps, 24 root steps, plus setup.
// Synchronous reset clears the accumulator's sums and counts, the column counter and the handshakes.
// A held result does not block new samples; only the next column's finish waits on it.
module column_mean_and_std_dev_core import cmsd_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   input  logic                       req_last_in_column,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [COL_W-1:0]           rsp_column_index,
   output logic signed [MEAN_W-1:0]   rsp_column_mean,
   output logic [STD_W-1:0]           rsp_column_std_dev,
   output logic                       rsp_row_overflow
);

   typedef enum logic [1:0] {T_IDLE, T_ACC, T_START, T_CALC} top_state_type;

   top_state_type   state_ff;
   logic            last_ff;
   logic [COL_W-1:0] col_ff;
   logic            rsp_valid_ff;
   logic [COL_W-1:0] rsp_index_ff;
   logic [MEAN_W-1:0] rsp_mean_ff;
   logic [STD_W-1:0] rsp_std_ff;
   logic            rsp_ovf_ff;

   acc_ctrl_type    acc_ctrl;
   col_stats_type   stats;
   seq_ctrl_type    seq_ctrl;
   seq_stat_type    seq_stat;
   col_result_type  result;

   logic            accept;
   logic            out_load;

   assign req_stall = (state_ff != T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == T_CALC) && seq_stat.done && (!rsp_valid_ff || !rsp_stall);

   assign acc_ctrl.take  = accept;
   assign acc_ctrl.accum = (state_ff == T_ACC);
   assign acc_ctrl.clear = (state_ff == T_START);
   assign seq_ctrl.start = (state_ff == T_START);
   assign seq_ctrl.ack   = out_load;

   cmsd_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (acc_ctrl),
      .sample (req_sample_value),
      .stats  (stats)
   );

   cmsd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (seq_ctrl),
      .stats  (stats),
      .stat   (seq_stat),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  last_ff  <= req_last_in_column;
                  state_ff <= T_ACC;
               end
            end
            T_ACC: begin
               state_ff <= last_ff ? T_START : T_IDLE;
            end
            T_START: begin
               state_ff <= T_CALC;
            end
            T_CALC: begin
               if (out_load) begin
                  state_ff <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_index_ff <= col_ff;
            rsp_mean_ff  <= result.mean;
            rsp_std_ff   <= result.std;
            rsp_ovf_ff   <= result.ovf;
            col_ff       <= (col_ff == COL_LAST) ? '0 : col_ff + COL_W'(1);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_column_index   = rsp_index_ff;
   assign rsp_column_mean    = rsp_mean_ff;
   assign rsp_column_std_dev = rsp_std_ff;
   assign rsp_row_overflow   = rsp_ovf_ff;

   a_accept_stalls: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("sample beat taken while previous still in work");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_START) |=> seq_stat.busy)
      else $error("sequencer did not start");

   a_load_index: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid && (rsp_column_index == $past(col_ff))))
      else $error("result beat lost or wrong column index");

endmodule
